### src/ppcld_pkg.sv
// ----------------------------------------------------------------------------
// ppcld_pkg: shared types and constants of the load unit
// Holds the load kind codes, the result kinds and the front-to-back record.
// ----------------------------------------------------------------------------
package ppcld_pkg;

    localparam int DISP_BITS     = 16;
    localparam int DS_CLEAR_BITS = 2;

    typedef enum logic [2:0] {
        K_LBZ = 3'd0, K_LHZ = 3'd1, K_LHA = 3'd2, K_LWZ = 3'd3,
        K_LWA = 3'd4, K_LD  = 3'd5, K_LFS = 3'd6, K_LFD = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        OK_READ = 2'd0, OK_GPR = 2'd1, OK_FPR = 2'd2
    } t_out_kind;

    typedef enum logic [1:0] {
        AM_D = 2'd0, AM_DS = 2'd1, AM_X = 2'd2, AM_X3 = 2'd3
    } t_amode;

    // One classified item handed from front to back.
    typedef struct packed {
        logic        is_data;   // 1: memory return, 0: issue
        logic        upd;
        logic [4:0]  base;
        logic [63:0] ea;
        logic [2:0]  kind;
        logic [4:0]  dest;
        logic [63:0] data;
    } t_op;

endpackage

### src/ppcld_front.sv
// ----------------------------------------------------------------------------
// ppcld_front: issue stage
// Accepts items, forms the effective address and queues a classified record.
// ----------------------------------------------------------------------------
module ppcld_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_req_type,
    input  logic [2:0]         i_load_kind,
    input  logic [1:0]         i_addr_mode,
    input  logic               i_update,
    input  logic [15:0]        i_displacement,
    input  logic [4:0]         i_base_reg,
    input  logic [63:0]        i_base_value,
    input  logic [63:0]        i_index_value,
    input  logic [4:0]         i_dest_reg,
    input  logic [63:0]        i_mem_data,
    output logic               o_valid,
    input  logic               i_stall,
    output ppcld_pkg::t_op     o_op
);
    ppcld_pkg::t_op r_op;
    logic           r_valid;
    ppcld_pkg::t_op n_op;
    logic [63:0]    w_off;
    logic [15:0]    w_ds;

    assign o_stall = r_valid && i_stall;
    assign w_ds = {i_displacement[15:ppcld_pkg::DS_CLEAR_BITS],
                   {ppcld_pkg::DS_CLEAR_BITS{1'b0}}};

    always_comb begin
        unique case (ppcld_pkg::t_amode'(i_addr_mode))
            ppcld_pkg::AM_D:  w_off = {{(64 - ppcld_pkg::DISP_BITS){i_displacement[15]}},
                                       i_displacement};
            ppcld_pkg::AM_DS: w_off = {{(64 - ppcld_pkg::DISP_BITS){w_ds[15]}}, w_ds};
            default:          w_off = i_index_value;
        endcase
        n_op.is_data = i_req_type;
        n_op.upd     = i_update;
        n_op.base    = i_base_reg;
        n_op.ea      = (i_update || i_base_reg != 5'd0) ? w_off + i_base_value : w_off;
        n_op.kind    = i_load_kind;
        n_op.dest    = i_dest_reg;
        n_op.data    = i_mem_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_op <= n_op;
        end
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;
endmodule

### src/ppcld_queue.sv
// ----------------------------------------------------------------------------
// ppcld_queue: two-entry queue between front and back
// Decouples the two sides so each may stall on its own.
// ----------------------------------------------------------------------------
module ppcld_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  ppcld_pkg::t_op i_op,
    output logic           o_valid,
    input  logic           i_stall,
    output ppcld_pkg::t_op o_op
);
    ppcld_pkg::t_op r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_op    = r_mem[r_rp];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) begin
            r_mem[r_wp] <= i_op;
        end
    end
endmodule

### src/ppcld_back.sv
// ----------------------------------------------------------------------------
// ppcld_back: execute stage
// Emits update writes and read requests, tracks the pending load and formats
// returned data into a register write.
// ----------------------------------------------------------------------------
module ppcld_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  ppcld_pkg::t_op i_op,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [1:0]     o_out_kind,
    output logic [63:0]    o_address,
    output logic [1:0]     o_access_size,
    output logic [4:0]     o_reg_index,
    output logic [63:0]    o_write_value,
    output logic           o_last
);
    logic        r_pvalid;
    logic [2:0]  r_pkind;
    logic [4:0]  r_pdest;
    logic        r_upd_done;  // update write of the head item already sent
    logic        r_ovalid;
    logic [1:0]  r_kind;
    logic [63:0] r_addr;
    logic [1:0]  r_size;
    logic [4:0]  r_reg;
    logic [63:0] r_val;
    logic        r_last;

    logic        w_oready;
    logic        w_emit;
    logic        w_emit_upd;
    logic        w_consume;
    logic [1:0]  w_size;
    logic [63:0] w_fmt;
    logic [63:0] w_sd;
    logic [31:0] w_w;
    logic [7:0]  w_exp;
    logic [22:0] w_frac;
    logic [4:0]  w_p;
    logic [51:0] w_nf;

    assign w_oready = !r_ovalid || !i_stall;
    assign w_emit_upd = !i_op.is_data && i_op.upd && !r_upd_done;
    // A data return with nothing pending is dropped without output.
    assign w_emit    = i_valid && w_oready && !(i_op.is_data && !r_pvalid);
    assign w_consume = i_valid && (w_oready || (i_op.is_data && !r_pvalid)) &&
                       !w_emit_upd;
    assign o_stall   = !w_consume;

    always_comb begin
        unique case (ppcld_pkg::t_kind'(i_op.kind)) inside
            ppcld_pkg::K_LBZ: w_size = 2'd0;
            ppcld_pkg::K_LHZ, ppcld_pkg::K_LHA: w_size = 2'd1;
            ppcld_pkg::K_LWZ, ppcld_pkg::K_LWA, ppcld_pkg::K_LFS: w_size = 2'd2;
            default: w_size = 2'd3;
        endcase
    end

    // Single to double widening; denormals are normalized.
    always_comb begin
        w_w    = i_op.data[31:0];
        w_exp  = w_w[30:23];
        w_frac = w_w[22:0];
        w_p    = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (w_frac[i]) w_p = 5'(i);
        end
        w_nf = 52'({29'd0, w_frac} << (6'd52 - {1'b0, w_p}));
        if (w_exp == 8'hFF)
            w_sd = {w_w[31], 11'h7FF, w_frac, 29'd0};
        else if (w_exp != 8'd0)
            w_sd = {w_w[31], 11'({3'd0, w_exp} + 11'd896), w_frac, 29'd0};
        else if (w_frac == 23'd0)
            w_sd = {w_w[31], 63'd0};
        else
            w_sd = {w_w[31], 11'({6'd0, w_p} + 11'd874), w_nf};
    end

    always_comb begin
        unique case (ppcld_pkg::t_kind'(r_pkind))
            ppcld_pkg::K_LBZ: w_fmt = {56'd0, i_op.data[7:0]};
            ppcld_pkg::K_LHZ: w_fmt = {48'd0, i_op.data[15:0]};
            ppcld_pkg::K_LHA: w_fmt = {{48{i_op.data[15]}}, i_op.data[15:0]};
            ppcld_pkg::K_LWZ: w_fmt = {32'd0, i_op.data[31:0]};
            ppcld_pkg::K_LWA: w_fmt = {{32{i_op.data[31]}}, i_op.data[31:0]};
            ppcld_pkg::K_LFS: w_fmt = w_sd;
            default:          w_fmt = i_op.data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid   <= 1'b0;
            r_pkind    <= 3'd0;
            r_pdest    <= 5'd0;
            r_upd_done <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (w_oready) r_ovalid <= w_emit;
            if (w_emit && w_emit_upd) r_upd_done <= 1'b1;
            else if (w_consume)       r_upd_done <= 1'b0;
            if (w_consume) begin
                if (!i_op.is_data) begin
                    r_pvalid <= 1'b1;
                    r_pkind  <= i_op.kind;
                    r_pdest  <= i_op.dest;
                end else begin
                    r_pvalid <= 1'b0;
                end
            end
        end
        if (w_emit) begin
            if (i_op.is_data) begin
                r_kind <= (r_pkind >= ppcld_pkg::K_LFS) ? ppcld_pkg::OK_FPR
                                                        : ppcld_pkg::OK_GPR;
                r_addr <= 64'd0;
                r_size <= 2'd0;
                r_reg  <= r_pdest;
                r_val  <= w_fmt;
                r_last <= 1'b1;
            end else if (w_emit_upd) begin
                r_kind <= ppcld_pkg::OK_GPR;
                r_addr <= 64'd0;
                r_size <= 2'd0;
                r_reg  <= i_op.base;
                r_val  <= i_op.ea;
                r_last <= 1'b0;
            end else begin
                r_kind <= ppcld_pkg::OK_READ;
                r_addr <= i_op.ea;
                r_size <= w_size;
                r_reg  <= 5'd0;
                r_val  <= 64'd0;
                r_last <= 1'b1;
            end
        end
    end

    assign o_valid       = r_ovalid;
    assign o_out_kind    = r_kind;
    assign o_address     = r_addr;
    assign o_access_size = r_size;
    assign o_reg_index   = r_reg;
    assign o_write_value = r_val;
    assign o_last        = r_last;
endmodule

### src/powerpc_load_unit.sv
// ----------------------------------------------------------------------------
// powerpc_load_unit: integer and float load unit
// Effective address, read request, and extension of returned data.
// ----------------------------------------------------------------------------
// One item enters per cycle unless a full queue holds the front stage. An issue
// item goes via the front register, queue and back output register to a read
// request; an update load first yields its base write, so it occupies the back
// stage until both are sent. A data return yields one register write. Results
// keep input order; a data return with no load pending gives nothing. The
// front stage forms the address, a two-entry queue decouples it from the
// back stage, which holds the single pending load and a registered output.
module powerpc_load_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [2:0]  i_load_kind,
    input  logic [1:0]  i_addr_mode,
    input  logic        i_update,
    input  logic [15:0] i_displacement,
    input  logic [4:0]  i_base_reg,
    input  logic [63:0] i_base_value,
    input  logic [63:0] i_index_value,
    input  logic [4:0]  i_dest_reg,
    input  logic [63:0] i_mem_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_out_kind,
    output logic [63:0] o_address,
    output logic [1:0]  o_access_size,
    output logic [4:0]  o_reg_index,
    output logic [63:0] o_write_value,
    output logic        o_last
);
    ppcld_pkg::t_op w_f_op;
    ppcld_pkg::t_op w_q_op;
    logic w_f_valid, w_q_stall, w_q_valid, w_b_stall;

    // Classify and form the address.
    ppcld_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_req_type, .i_load_kind, .i_addr_mode, .i_update, .i_displacement,
        .i_base_reg, .i_base_value, .i_index_value, .i_dest_reg, .i_mem_data,
        .o_valid(w_f_valid), .i_stall(w_q_stall), .o_op(w_f_op)
    );

    // Buffer between front and back.
    ppcld_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(w_f_valid), .o_stall(w_q_stall), .i_op(w_f_op),
        .o_valid(w_q_valid), .i_stall(w_b_stall), .o_op(w_q_op)
    );

    // Carry out: emit writes and requests.
    ppcld_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_q_valid), .o_stall(w_b_stall), .i_op(w_q_op),
        .o_valid, .i_stall, .o_out_kind, .o_address, .o_access_size,
        .o_reg_index, .o_write_value, .o_last
    );
endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the load unit
// Drives issue and data-return items through the valid/stall channels, predicts
// every read request and register write, and compares them in order.
// ----------------------------------------------------------------------------
module tb_top;

    // Result record as seen on the output channel.
    typedef struct packed {
        logic [1:0]  okind;
        logic [63:0] addr;
        logic [1:0]  size;
        logic [4:0]  reg_idx;
        logic [63:0] value;
        logic        last;
    } t_res;

    // One input item.
    typedef struct packed {
        logic        req;
        logic [2:0]  kind;
        logic [1:0]  mode;
        logic        upd;
        logic [15:0] disp;
        logic [4:0]  base;
        logic [63:0] bval;
        logic [63:0] ival;
        logic [4:0]  dest;
        logic [63:0] data;
    } t_item;

    localparam longint CYCLE_LIMIT = 400000;
    localparam int     DRAIN_CYCLES = 12;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_req_type;
    logic [2:0]  i_load_kind;
    logic [1:0]  i_addr_mode;
    logic        i_update;
    logic [15:0] i_displacement;
    logic [4:0]  i_base_reg;
    logic [63:0] i_base_value;
    logic [63:0] i_index_value;
    logic [4:0]  i_dest_reg;
    logic [63:0] i_mem_data;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_out_kind;
    logic [63:0] o_address;
    logic [1:0]  o_access_size;
    logic [4:0]  o_reg_index;
    logic [63:0] o_write_value;
    logic        o_last;

    powerpc_load_unit dut (.*);

    // Predictor state: the load that awaits its data.
    logic               ld_pending;
    ppcld_pkg::t_kind   ld_kind;
    logic [4:0]         ld_dest;

    t_res   expected_q[$];
    int     mismatch_cnt = 0;
    longint cycle_cnt = 0;
    int     send_idle_pct;
    int     recv_idle_pct;
    bit     hold_recv;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [63:0] sext_half(logic [63:0] v);
        return {{48{v[15]}}, v[15:0]};
    endfunction

    // Widen an IEEE single to a double, normalizing denormals.
    function automatic logic [63:0] widen_single(logic [31:0] w);
        logic [7:0]  e;
        logic [22:0] f;
        logic [51:0] fr;
        int          p;
        e = w[30:23];
        f = w[22:0];
        if (e == 8'hFF) return {w[31], 11'h7FF, f, 29'b0};
        if (e != 0) return {w[31], 11'({3'b000, e} + 11'd896), f, 29'b0};
        if (f == 0) return {w[31], 63'b0};
        p = 22;
        while (f[p] == 1'b0) p--;
        fr = 52'({29'b0, f} << (52 - p));
        return {w[31], 11'(p + 874), fr};
    endfunction

    function automatic logic [1:0] size_of(ppcld_pkg::t_kind k);
        case (k) inside
            ppcld_pkg::K_LBZ:                                   return 2'd0;
            ppcld_pkg::K_LHZ, ppcld_pkg::K_LHA:                 return 2'd1;
            ppcld_pkg::K_LWZ, ppcld_pkg::K_LWA, ppcld_pkg::K_LFS: return 2'd2;
            default:                                            return 2'd3;
        endcase
    endfunction

    // Push the results that one accepted item produces.
    function automatic void predict_load(t_item it);
        logic [63:0] ea;
        logic [63:0] v;
        t_res        r;
        if (!it.req) begin
            case (ppcld_pkg::t_amode'(it.mode))
                ppcld_pkg::AM_D:  ea = sext_half({48'b0, it.disp});
                ppcld_pkg::AM_DS: ea = sext_half({48'b0, it.disp[15:2], 2'b00});
                default:          ea = it.ival;
            endcase
            if (it.upd || it.base != 0) ea = ea + it.bval;
            if (it.upd) begin
                r = '{ppcld_pkg::OK_GPR, 64'b0, 2'd0, it.base, ea, 1'b0};
                expected_q.push_back(r);
            end
            r = '{ppcld_pkg::OK_READ, ea, size_of(ppcld_pkg::t_kind'(it.kind)), 5'd0,
                  64'b0, 1'b1};
            expected_q.push_back(r);
            ld_pending = 1'b1;
            ld_kind = ppcld_pkg::t_kind'(it.kind);
            ld_dest = it.dest;
            return;
        end
        if (!ld_pending) return;
        ld_pending = 1'b0;
        case (ld_kind)
            ppcld_pkg::K_LBZ: v = {56'b0, it.data[7:0]};
            ppcld_pkg::K_LHZ: v = {48'b0, it.data[15:0]};
            ppcld_pkg::K_LHA: v = sext_half(it.data);
            ppcld_pkg::K_LWZ: v = {32'b0, it.data[31:0]};
            ppcld_pkg::K_LWA: v = {{32{it.data[31]}}, it.data[31:0]};
            ppcld_pkg::K_LFS: v = widen_single(it.data[31:0]);
            default:          v = it.data;
        endcase
        r = '{(ld_kind >= ppcld_pkg::K_LFS) ? ppcld_pkg::OK_FPR : ppcld_pkg::OK_GPR,
              64'b0, 2'd0, ld_dest, v, 1'b1};
        expected_q.push_back(r);
    endfunction

    // Compare every accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_res got;
        t_res exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_out_kind, o_address, o_access_size, o_reg_index,
                    o_write_value, o_last};
            if (expected_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result %h", got);
            end else begin
                exp_r = expected_q.pop_front();
                if (got !== exp_r) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("result mismatch: expected %h, got %h", exp_r, got);
                end
            end
        end
    end

    // Count cycles and stop a hung run.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Drive the receiver stall at the falling edge; hold it high on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else if (hold_recv) i_stall <= 1'b1;
        else i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Place one item on the input and wait for acceptance; valid stays high.
    task automatic send_item(t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_req_type     <= it.req;
        i_load_kind    <= it.kind;
        i_addr_mode    <= it.mode;
        i_update       <= it.upd;
        i_displacement <= it.disp;
        i_base_reg     <= it.base;
        i_base_value   <= it.bval;
        i_index_value  <= it.ival;
        i_dest_reg     <= it.dest;
        i_mem_data     <= it.data;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_load(it);
        @(negedge i_clk);
    endtask

    function automatic t_item rand_item(bit is_data);
        t_item it;
        it.req  = is_data;
        it.kind = 3'($urandom_range(7));
        it.mode = 2'($urandom_range(3));
        it.upd  = ($urandom_range(3) == 0);
        it.disp = 16'($urandom);
        it.base = ($urandom_range(7) == 0) ? 5'd0 : 5'($urandom);
        it.bval = {$urandom, $urandom};
        it.ival = {$urandom, $urandom};
        it.dest = 5'($urandom);
        case ($urandom_range(3))
            0:       it.data = {$urandom, $urandom};
            1:       it.data = {32'($urandom), 1'($urandom), 8'h00, 23'($urandom)};
            2:       it.data = {32'($urandom), 1'($urandom), 8'hFF, 23'($urandom)};
            default: it.data = {32'($urandom), 1'($urandom), 8'($urandom), 23'($urandom)};
        endcase
        return it;
    endfunction

    // Drop valid and wait until every expected result has come.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (expected_q.size() != 0) @(negedge i_clk);
    endtask

    // Directed rows: issue loads over every kind and mode, interleaved with data returns.
    // Rows with a typed expectation are checked against it instead.
    t_item dir_tab[22];
    t_res  dir_exp[22];
    bit    dir_has[22];

    initial begin
        t_item it;
        int    n;
        i_rst_n = 1'b0; i_valid = 1'b0;
        i_req_type = 0; i_load_kind = 0; i_addr_mode = 0; i_update = 0;
        i_displacement = 0; i_base_reg = 0; i_base_value = 0;
        i_index_value = 0; i_dest_reg = 0; i_mem_data = 0;
        ld_pending = 0; ld_kind = ppcld_pkg::K_LBZ; ld_dest = 0;
        hold_recv = 0;
        send_idle_pct = 0; recv_idle_pct = 0;
        foreach (dir_has[k]) dir_has[k] = 0;
        // data with nothing pending after reset: dropped
        dir_tab[0]  = '{1, ppcld_pkg::K_LD,  ppcld_pkg::AM_D,  0, 16'h0000, 5'd0, 0, 0,
                        5'd1, '1};
        // r0 base without update reads zero; extreme negative displacement
        dir_tab[1]  = '{0, ppcld_pkg::K_LBZ, ppcld_pkg::AM_D,  0, 16'h8000, 5'd0, 64'h55, 0,
                        5'd3, 0};
        dir_exp[1]  = '{ppcld_pkg::OK_READ, 64'hFFFF_FFFF_FFFF_8000, 2'd0, 5'd0, 0, 1};
        dir_has[1]  = 1;
        dir_tab[2]  = '{1, 0, 0, 0, 0, 0, 0, 0, 0, '1};   // wider data ignored
        dir_exp[2]  = '{ppcld_pkg::OK_GPR, 0, 2'd0, 5'd3, 64'hFF, 1};
        dir_has[2]  = 1;
        dir_tab[3]  = '{0, ppcld_pkg::K_LHZ, ppcld_pkg::AM_DS, 0, 16'h7FFF, 5'd4, '1, 0,
                        5'd31, 0};
        dir_tab[4]  = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 64'h8001};
        // update with base r0
        dir_tab[5]  = '{0, ppcld_pkg::K_LHA, ppcld_pkg::AM_X,  1, 0, 5'd0, 64'h10, '1,
                        5'd2, 0};
        dir_tab[6]  = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 64'hFFFF};
        dir_exp[6]  = '{ppcld_pkg::OK_GPR, 0, 2'd0, 5'd2, '1, 1};
        dir_has[6]  = 1;
        // unused address mode behaves as indexed
        dir_tab[7]  = '{0, ppcld_pkg::K_LWZ, ppcld_pkg::AM_X3, 0, 0, 5'd31, '1, '1, 5'd5, 0};
        dir_tab[8]  = '{1, 0, 0, 0, 0, 0, 0, 0, 0, '1};
        dir_tab[9]  = '{0, ppcld_pkg::K_LWA, ppcld_pkg::AM_D,  1, 16'hFFFC, 5'd9, 64'h100, 0,
                        5'd6, 0};
        dir_tab[10] = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 64'h8000_0000};
        dir_exp[10] = '{ppcld_pkg::OK_GPR, 0, 2'd0, 5'd6, 64'hFFFF_FFFF_8000_0000, 1};
        dir_has[10] = 1;
        dir_tab[11] = '{0, ppcld_pkg::K_LD,  ppcld_pkg::AM_DS, 1, 16'hFFFF, 5'd1, 0, 0,
                        5'd7, 0};
        dir_tab[12] = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 64'h0123_4567_89AB_CDEF};
        dir_tab[13] = '{0, ppcld_pkg::K_LFS, ppcld_pkg::AM_D,  0, 0, 5'd2, 0, 0, 5'd8, 0};
        dir_tab[14] = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 64'h0000_0001};   // denormal
        dir_tab[15] = '{0, ppcld_pkg::K_LFS, ppcld_pkg::AM_D,  0, 0, 5'd2, 0, 0, 5'd8, 0};
        dir_tab[16] = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 64'h7F80_0001};   // signaling NaN
        dir_tab[17] = '{0, ppcld_pkg::K_LFS, ppcld_pkg::AM_D,  0, 0, 5'd2, 0, 0, 5'd8, 0};
        dir_tab[18] = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 64'h8000_0000};   // minus zero
        dir_exp[18] = '{ppcld_pkg::OK_FPR, 0, 2'd0, 5'd8, 64'h8000_0000_0000_0000, 1};
        dir_has[18] = 1;
        dir_tab[19] = '{0, ppcld_pkg::K_LBZ, ppcld_pkg::AM_D,  0, 0, 5'd2, 0, 0, 5'd9, 0};
        // replaces the pending load
        dir_tab[20] = '{0, ppcld_pkg::K_LFD, ppcld_pkg::AM_X,  0, 0, 5'd3, 1, 2, 5'd10, 0};
        dir_tab[21] = '{1, 0, 0, 0, 0, 0, 0, 0, 0, '1};
        dir_exp[21] = '{ppcld_pkg::OK_FPR, 0, 2'd0, 5'd10, '1, 1};
        dir_has[21] = 1;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < 22; r++) begin
            send_item(dir_tab[r]);
            // the result of this row is still queued; hold it to the typed value
            if (dir_has[r]) expected_q[expected_q.size() - 1] = dir_exp[r];
            wait_drained();
        end

        // Random part in three idling phases, plus a pressure burst in the second.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 54 : 0;
            recv_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 14 : 0;
            n = 0;
            while (n < 580) begin
                // mostly issue/data pairs, some stray returns and double issues
                if ($urandom_range(9) == 0) begin
                    it = rand_item(1'($urandom_range(1)));
                    send_item(it);
                    n++;
                end else begin
                    send_item(rand_item(1'b0));
                    send_item(rand_item(1'b1));
                    n += 2;
                end
                if (ph == 1 && n > 200 && n < 204) begin
                    // hold the receiver off while the sender keeps offering
                    fork
                        begin
                            hold_recv = 1;
                            repeat (60) @(negedge i_clk);
                            hold_recv = 0;
                        end
                        begin
                            for (int j = 0; j < 12; j++) send_item(rand_item(1'(j % 2)));
                        end
                    join
                    n += 12;
                end
                if (n % 150 < 2) wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
